>>> design/assert_macros.svh
// Assertion macros for the glyph framebuffer renderer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define GFR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gfr assertion failed");

// Check that a condition is followed by another in the next cycle.
`define GFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfr sequence assertion failed");

`else

`define GFR_ASSERT(lbl, clk, rst_n, prop)
`define GFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/gfr_pkg.sv
// Shared types, codes and constants of the glyph framebuffer renderer.
package gfr_pkg;

    // Default geometry
    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int DEF_GLYPH_DEPTH   = 2048;

    // Width used for address arithmetic (covers the largest frame and glyph index)
    localparam int CALC_W = 14;
    // Width of a glyph word index: (126 - 32) * 31 + 30 fits in 12 bits
    localparam int GIDX_W = 12;

    // Printable character range
    localparam logic [7:0] FIRST_PRINT = 8'd32;
    localparam logic [7:0] LAST_PRINT  = 8'd126;

    // Function codes
    localparam logic [2:0] FUNC_DRAW   = 3'd0;
    localparam logic [2:0] FUNC_SETCUR = 3'd1;
    localparam logic [2:0] FUNC_CHAR   = 3'd2;
    localparam logic [2:0] FUNC_CLEAR  = 3'd3;
    localparam logic [2:0] FUNC_FILL   = 3'd4;
    localparam logic [2:0] FUNC_LOAD   = 3'd5;
    localparam logic [2:0] FUNC_READ   = 3'd6;

    // Configuration register indexes
    localparam logic REG_GLYPH_WIDTH  = 1'b0;
    localparam logic REG_GLYPH_HEIGHT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [4:0] RST_GLYPH_WIDTH  = 5'd7;
    localparam logic [4:0] RST_GLYPH_HEIGHT = 5'd10;

    // Frame memory address source
    typedef enum logic [1:0] {
        ASEL_PIX,
        ASEL_CHAR,
        ASEL_SWEEP,
        ASEL_BYTE
    } asel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  capture;
        logic  decode;
        logic  fb_rd;
        logic  fb_wr;
        asel_t addr_sel;
        logic  fill_ones;
        logic  gl_rd;
        logic  gl_wr;
        logic  char_init;
        logic  row_next;
        logic  col_inc;
        logic  sweep_clr;
        logic  sweep_inc;
        logic  cur_set;
        logic  cur_adv;
        logic  out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] func;
        logic       on_screen;
        logic       char_ok;
        logic       dim_zero;
        logic       j_last;
        logic       i_last;
        logic       font_ok;
        logic       sweep_last;
    } dp_status_t;

endpackage

>>> design/glyph_framebuffer_renderer.sv
// Top level: configuration registers, stream packing, controller and datapath.
// Flow: a word is captured in IDLE, decoded, its result loaded in DONE; the next is taken in IDLE.
// Draw pixel adds a write state (frame byte read-modify-write on the single memory port).
// Write char does one frame read and one frame write per glyph pixel.
// Clear and fill sweep every frame byte, one frame byte written per cycle.
// Reset: cursor 0, glyph size 7x10; a clearing pass over every frame byte holds s_tready low.
module glyph_framebuffer_renderer #(
    parameter int SCREEN_WIDTH  = gfr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = gfr_pkg::DEF_SCREEN_HEIGHT,
    parameter int GLYPH_DEPTH   = gfr_pkg::DEF_GLYPH_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input word stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x[7:0], pos_y[15:8], pixel_on[16], char_code[24:17], font_addr[35:25],
    // font_row[51:36], byte_addr[61:52], zero[63:62]
    input  logic [63:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    // Result word stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // char_echo[7:0], read_byte[15:8], cursor_col[23:16], cursor_row[31:24]
    output logic [31:0] m_tdata
);
    import gfr_pkg::*;

    logic [4:0] glyph_width_reg;
    logic [4:0] glyph_height_reg;
    logic       cfg_wr;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic [7:0] char_echo;
    logic [7:0] read_byte;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg  <= RST_GLYPH_WIDTH;
            glyph_height_reg <= RST_GLYPH_HEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_GLYPH_WIDTH:  glyph_width_reg  <= pwdata[4:0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= pwdata[4:0];
                default:          glyph_width_reg  <= glyph_width_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            REG_GLYPH_WIDTH:  prdata = 32'(glyph_width_reg);
            REG_GLYPH_HEIGHT: prdata = 32'(glyph_height_reg);
            default:          prdata = 32'h0;
        endcase
    end

    gfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gfr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .GLYPH_DEPTH   (GLYPH_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (s_tuser[2:0]),
        .pos_x        (s_tdata[7:0]),
        .pos_y        (s_tdata[15:8]),
        .pixel_on     (s_tdata[16]),
        .char_code    (s_tdata[24:17]),
        .font_addr    (s_tdata[35:25]),
        .font_row     (s_tdata[51:36]),
        .byte_addr    (s_tdata[61:52]),
        .glyph_width  (glyph_width_reg),
        .glyph_height (glyph_height_reg),
        .cmd          (cmd),
        .status       (status),
        .char_echo    (char_echo),
        .read_byte    (read_byte),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row)
    );

    // Pack the result word
    assign m_tdata = {cursor_row, cursor_col, read_byte, char_echo};

endmodule

>>> design/gfr_datapath.sv
// Datapath: frame and glyph memories, cursor, counters and result register.
module gfr_datapath #(
    parameter int SCREEN_WIDTH  = gfr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = gfr_pkg::DEF_SCREEN_HEIGHT,
    parameter int GLYPH_DEPTH   = gfr_pkg::DEF_GLYPH_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          func,
    input  logic [7:0]          pos_x,
    input  logic [7:0]          pos_y,
    input  logic                pixel_on,
    input  logic [7:0]          char_code,
    input  logic [10:0]         font_addr,
    input  logic [15:0]         font_row,
    input  logic [9:0]          byte_addr,
    input  logic [4:0]          glyph_width,
    input  logic [4:0]          glyph_height,
    input  gfr_pkg::dp_cmd_t    cmd,
    output gfr_pkg::dp_status_t status,
    output logic [7:0]          char_echo,
    output logic [7:0]          read_byte,
    output logic [7:0]          cursor_col,
    output logic [7:0]          cursor_row
);
    import gfr_pkg::*;

    localparam int FRAME_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
    localparam int FA_W        = $clog2(FRAME_BYTES);
    localparam int GA_W        = $clog2(GLYPH_DEPTH);

    // Captured item
    logic [2:0]        func_reg;
    logic [7:0]        pos_x_reg;
    logic [7:0]        pos_y_reg;
    logic              pixel_on_reg;
    logic [7:0]        char_code_reg;
    logic [10:0]       font_addr_reg;
    logic [15:0]       font_row_reg;
    logic [9:0]        byte_addr_reg;

    // Sequencing state
    logic [7:0]        text_col_reg;
    logic [7:0]        text_row_reg;
    logic [GIDX_W-1:0] gidx_reg;
    logic [4:0]        gi_reg;
    logic [4:0]        gj_reg;
    logic [FA_W-1:0]   sweep_reg;
    logic              echo_ok_reg;

    // Memory read data
    logic [15:0]       grow_reg;
    logic [7:0]        fb_rdata_reg;

    // Result word
    logic [7:0]        echo_reg;
    logic [7:0]        rbyte_reg;
    logic [7:0]        ocol_reg;
    logic [7:0]        orow_reg;

    // Memories
    logic [7:0]        fmem [FRAME_BYTES];
    logic [15:0]       gmem [GLYPH_DEPTH];

    logic [6:0]        char_off;
    logic [8:0]        chr_x;
    logic [8:0]        chr_y;
    logic [CALC_W-1:0] pix_addr;
    logic [CALC_W-1:0] chr_addr;
    logic [CALC_W-1:0] sweep_ext;
    logic [CALC_W-1:0] byte_ext;
    logic [CALC_W-1:0] fb_addr_ext;
    logic [CALC_W-1:0] gidx_ext;
    logic [CALC_W-1:0] faddr_ext;
    logic [FA_W-1:0]   fb_addr;
    logic [7:0]        pix_bit;
    logic [7:0]        chr_bit;
    logic              chr_on;
    logic [7:0]        fb_wdata;
    logic              printable;
    logic              col_fit;
    logic              row_fit;
    logic              byte_ok;

    // Address arithmetic
    assign char_off  = 7'(char_code_reg - FIRST_PRINT);
    assign chr_x     = 9'(text_col_reg) + 9'(gj_reg);
    assign chr_y     = 9'(text_row_reg) + 9'(gi_reg);
    assign pix_addr  = CALC_W'(pos_x_reg) + CALC_W'(SCREEN_WIDTH) * CALC_W'(pos_y_reg[7:3]);
    assign chr_addr  = CALC_W'(chr_x) + CALC_W'(SCREEN_WIDTH) * CALC_W'(chr_y[8:3]);
    assign sweep_ext = CALC_W'(sweep_reg);
    assign byte_ext  = CALC_W'(byte_addr_reg);
    assign gidx_ext  = CALC_W'(gidx_reg);
    assign faddr_ext = CALC_W'(font_addr_reg);

    // Select the frame memory address
    always_comb
    begin
        unique case (cmd.addr_sel)
            ASEL_PIX:   fb_addr_ext = pix_addr;
            ASEL_CHAR:  fb_addr_ext = chr_addr;
            ASEL_SWEEP: fb_addr_ext = sweep_ext;
            ASEL_BYTE:  fb_addr_ext = byte_ext;
            default:    fb_addr_ext = pix_addr;
        endcase
    end
    assign fb_addr = fb_addr_ext[FA_W-1:0];

    // Build the modified byte for the current write
    assign pix_bit = 8'b1 << pos_y_reg[2:0];
    assign chr_bit = 8'b1 << chr_y[2:0];
    assign chr_on  = (gj_reg < 5'd16) ? grow_reg[4'd15 - gj_reg[3:0]] : 1'b0;

    always_comb
    begin
        unique case (cmd.addr_sel)
            ASEL_PIX:   fb_wdata = pixel_on_reg ? (fb_rdata_reg | pix_bit)
                                                : (fb_rdata_reg & ~pix_bit);
            ASEL_CHAR:  fb_wdata = chr_on ? (fb_rdata_reg | chr_bit)
                                          : (fb_rdata_reg & ~chr_bit);
            ASEL_SWEEP: fb_wdata = cmd.fill_ones ? 8'hFF : 8'h00;
            default:    fb_wdata = fb_rdata_reg;
        endcase
    end

    // Frame memory: one port, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.fb_wr)
        begin
            fmem[fb_addr] <= fb_wdata;
        end
        if (cmd.fb_rd)
        begin
            fb_rdata_reg <= fmem[fb_addr];
        end
    end

    // Glyph memory: load port and glyph row read, out-of-range rows read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.gl_wr)
        begin
            gmem[faddr_ext[GA_W-1:0]] <= font_row_reg;
        end
        if (cmd.gl_rd)
        begin
            grow_reg <= (32'(gidx_reg) < GLYPH_DEPTH) ? gmem[gidx_ext[GA_W-1:0]] : 16'h0000;
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg      <= func;
            pos_x_reg     <= pos_x;
            pos_y_reg     <= pos_y;
            pixel_on_reg  <= pixel_on;
            char_code_reg <= char_code;
            font_addr_reg <= font_addr;
            font_row_reg  <= font_row;
            byte_addr_reg <= byte_addr;
        end
    end

    // Cursor, glyph counters and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_col_reg <= 8'd0;
            text_row_reg <= 8'd0;
            gidx_reg     <= '0;
            gi_reg       <= 5'd0;
            gj_reg       <= 5'd0;
            sweep_reg    <= '0;
            echo_ok_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.decode)
            begin
                echo_ok_reg <= (func_reg == FUNC_CHAR) && status.char_ok;
            end
            if (cmd.char_init)
            begin
                gidx_reg <= GIDX_W'(char_off) * GIDX_W'(glyph_height);
                gi_reg   <= 5'd0;
                gj_reg   <= 5'd0;
            end
            else if (cmd.row_next)
            begin
                gidx_reg <= gidx_reg + GIDX_W'(1);
                gi_reg   <= gi_reg + 5'd1;
                gj_reg   <= 5'd0;
            end
            else if (cmd.col_inc)
            begin
                gj_reg <= gj_reg + 5'd1;
            end
            if (cmd.sweep_clr)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_inc)
            begin
                sweep_reg <= sweep_reg + FA_W'(1);
            end
            if (cmd.cur_set)
            begin
                text_col_reg <= pos_x_reg;
                text_row_reg <= pos_y_reg;
            end
            else if (cmd.cur_adv)
            begin
                text_col_reg <= text_col_reg + 8'(glyph_width);
            end
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            echo_reg  <= echo_ok_reg ? char_code_reg : 8'h00;
            rbyte_reg <= ((func_reg == FUNC_READ) && byte_ok) ? fb_rdata_reg : 8'h00;
            ocol_reg  <= text_col_reg;
            orow_reg  <= text_row_reg;
        end
    end

    // Status toward the controller
    assign printable = (char_code_reg >= FIRST_PRINT) && (char_code_reg <= LAST_PRINT);
    assign col_fit   = (32'(text_col_reg) + 32'(glyph_width)) <= SCREEN_WIDTH;
    assign row_fit   = (32'(text_row_reg) + 32'(glyph_height)) <= SCREEN_HEIGHT;
    assign byte_ok   = 32'(byte_addr_reg) < FRAME_BYTES;

    assign status.func       = func_reg;
    assign status.on_screen  = (32'(pos_x_reg) < SCREEN_WIDTH) && (32'(pos_y_reg) < SCREEN_HEIGHT);
    assign status.char_ok    = printable && col_fit && row_fit;
    assign status.dim_zero   = (glyph_width == 5'd0) || (glyph_height == 5'd0);
    assign status.j_last     = gj_reg == (glyph_width - 5'd1);
    assign status.i_last     = gi_reg == (glyph_height - 5'd1);
    assign status.font_ok    = 32'(font_addr_reg) < GLYPH_DEPTH;
    assign status.sweep_last = sweep_reg == FA_W'(FRAME_BYTES - 1);

    assign char_echo  = echo_reg;
    assign read_byte  = rbyte_reg;
    assign cursor_col = ocol_reg;
    assign cursor_row = orow_reg;

endmodule

>>> design/gfr_ctrl.sv
// Controller: state machine that sequences each function through the datapath.
`include "assert_macros.svh"

module gfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  gfr_pkg::dp_status_t status,
    output gfr_pkg::dp_cmd_t    cmd
);
    import gfr_pkg::*;

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DECODE = 4'd2;
    localparam logic [3:0] ST_PIX_WR = 4'd3;
    localparam logic [3:0] ST_CH_GRD = 4'd4;
    localparam logic [3:0] ST_CH_FRD = 4'd5;
    localparam logic [3:0] ST_CH_FWR = 4'd6;
    localparam logic [3:0] ST_SWEEP  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;

    // Next state and commands
    always_comb
    begin
        cmd          = '0;
        cmd.addr_sel = ASEL_PIX;
        state_next   = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.fb_wr     = 1'b1;
                cmd.addr_sel  = ASEL_SWEEP;
                cmd.sweep_inc = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = ST_DONE;
                unique case (status.func)
                    FUNC_DRAW:
                    begin
                        if (status.on_screen)
                        begin
                            cmd.fb_rd  = 1'b1;
                            state_next = ST_PIX_WR;
                        end
                    end
                    FUNC_SETCUR:
                    begin
                        cmd.cur_set = 1'b1;
                    end
                    FUNC_CHAR:
                    begin
                        if (status.char_ok && status.dim_zero)
                        begin
                            cmd.cur_adv = 1'b1;
                        end
                        else if (status.char_ok)
                        begin
                            cmd.char_init = 1'b1;
                            state_next    = ST_CH_GRD;
                        end
                    end
                    FUNC_CLEAR, FUNC_FILL:
                    begin
                        cmd.sweep_clr = 1'b1;
                        state_next    = ST_SWEEP;
                    end
                    FUNC_LOAD:
                    begin
                        cmd.gl_wr = status.font_ok;
                    end
                    FUNC_READ:
                    begin
                        cmd.fb_rd    = 1'b1;
                        cmd.addr_sel = ASEL_BYTE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PIX_WR:
            begin
                cmd.fb_wr  = 1'b1;
                state_next = ST_DONE;
            end
            ST_CH_GRD:
            begin
                cmd.gl_rd    = 1'b1;
                cmd.fb_rd    = 1'b1;
                cmd.addr_sel = ASEL_CHAR;
                state_next   = ST_CH_FWR;
            end
            ST_CH_FRD:
            begin
                cmd.fb_rd    = 1'b1;
                cmd.addr_sel = ASEL_CHAR;
                state_next   = ST_CH_FWR;
            end
            ST_CH_FWR:
            begin
                cmd.fb_wr    = 1'b1;
                cmd.addr_sel = ASEL_CHAR;
                if (status.j_last && status.i_last)
                begin
                    cmd.cur_adv = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (status.j_last)
                begin
                    cmd.row_next = 1'b1;
                    state_next   = ST_CH_GRD;
                end
                else
                begin
                    cmd.col_inc = 1'b1;
                    state_next  = ST_CH_FRD;
                end
            end
            ST_SWEEP:
            begin
                cmd.fb_wr     = 1'b1;
                cmd.addr_sel  = ASEL_SWEEP;
                cmd.fill_ones = status.func == FUNC_FILL;
                cmd.sweep_inc = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;

    // An accepted word is decoded in the next cycle
    `GFR_ASSERT_NEXT(a_accept_decode, clk, rst_n, s_tvalid && s_tready, state_reg == ST_DECODE)
    // Never overwrite a result word that is still waiting
    `GFR_ASSERT(a_no_overwrite, clk, rst_n, !(cmd.out_load && out_valid_reg && !m_tready))
    // The single frame port never reads and writes in the same cycle
    `GFR_ASSERT(a_rd_wr_excl, clk, rst_n, !(cmd.fb_rd && cmd.fb_wr))
    // A glyph pixel write always follows the read of its byte
    `GFR_ASSERT(a_fwr_after_rd, clk, rst_n, (state_reg == ST_CH_FWR) |-> ($past(state_reg) == ST_CH_FRD || $past(state_reg) == ST_CH_GRD))

endmodule

>>> sim/tb_glyph_framebuffer_renderer.sv
// Self-checking testbench for the glyph framebuffer renderer: stream stimulus and result checks.
`timescale 1ns / 100ps

module tb_glyph_framebuffer_renderer;
    import gfr_pkg::*;

    localparam int SCR_W    = DEF_SCREEN_WIDTH;
    localparam int SCR_H    = DEF_SCREEN_HEIGHT;
    localparam int GLYPHS   = DEF_GLYPH_DEPTH;
    localparam int FB_BYTES = SCR_W * ((SCR_H + 7) / 8);
    localparam int LAST_PAGE = (SCR_H - 1) / 8;
    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    // One command word as it travels on the input stream
    typedef struct packed {
        bit [2:0]  func;
        bit [7:0]  pos_x;
        bit [7:0]  pos_y;
        bit        pixel_on;
        bit [7:0]  char_code;
        bit [10:0] font_addr;
        bit [15:0] font_row;
        bit [9:0]  byte_addr;
    } glyph_cmd_t;

    // One result word, fields named as on the output stream
    typedef struct packed {
        bit [7:0] char_echo;
        bit [7:0] read_byte;
        bit [7:0] cursor_col;
        bit [7:0] cursor_row;
    } render_word_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // pos_x[7:0], pos_y[15:8], pixel_on[16], char_code[24:17], font_addr[35:25],
    // font_row[51:36], byte_addr[61:52], zero[63:62]
    logic [63:0] s_tdata  = '0;
    // func[2:0]
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // char_echo[7:0], read_byte[15:8], cursor_col[23:16], cursor_row[31:24]
    logic [31:0] m_tdata;

    // Mirror of the block state
    bit [7:0]  frame_mirror [FB_BYTES];
    bit [15:0] glyph_mirror [GLYPHS];
    bit        glyph_loaded [GLYPHS];
    bit [7:0]  text_col = 8'd0;
    bit [7:0]  text_row = 8'd0;
    bit [4:0]  glyph_w  = RST_GLYPH_WIDTH;
    bit [4:0]  glyph_h  = RST_GLYPH_HEIGHT;

    render_word_t expected_words[$];
    render_word_t head_word;

    int errors          = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int chars_drawn     = 0;
    int glyph_loads     = 0;
    int size_settings   = 0;
    int src_idle_pct    = 0;
    int snk_stall_pct   = 0;

    glyph_framebuffer_renderer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Set or clear one pixel; drop anything off screen
    function automatic void plot(int x, int y, bit on);
        int idx;
        if (x >= SCR_W || y >= SCR_H)
            return;
        idx = x + SCR_W * (y / 8);
        frame_mirror[idx][y % 8] = on;
    endfunction

    // Render one character at the cursor; return the echo
    function automatic bit [7:0] render_char(int c);
        int        i;
        int        j;
        int        word_idx;
        bit [15:0] row_bits;
        bit        on;
        if (c < FIRST_PRINT || c > LAST_PRINT)
            return 8'd0;
        if (text_col + glyph_w > SCR_W || text_row + glyph_h > SCR_H)
            return 8'd0;
        for (i = 0; i < glyph_h; i++)
        begin
            word_idx = (c - FIRST_PRINT) * glyph_h + i;
            row_bits = (word_idx < GLYPHS) ? glyph_mirror[word_idx] : 16'd0;
            for (j = 0; j < glyph_w; j++)
            begin
                // columns past the 16-bit row come out black
                on = (j < 16) ? row_bits[15 - j] : 1'b0;
                plot(text_col + j, text_row + i, on);
            end
        end
        text_col = text_col + glyph_w;
        chars_drawn++;
        return c[7:0];
    endfunction

    // Apply one command to the mirror and return the result word it yields
    function automatic render_word_t apply_cmd(glyph_cmd_t cmd);
        render_word_t res;
        res = '0;
        unique case (cmd.func)
            FUNC_DRAW:
                plot(cmd.pos_x, cmd.pos_y, cmd.pixel_on);
            FUNC_SETCUR:
            begin
                text_col = cmd.pos_x;
                text_row = cmd.pos_y;
            end
            FUNC_CHAR:
                res.char_echo = render_char(cmd.char_code);
            FUNC_CLEAR:
                foreach (frame_mirror[k])
                    frame_mirror[k] = 8'h00;
            FUNC_FILL:
                foreach (frame_mirror[k])
                    frame_mirror[k] = 8'hFF;
            FUNC_LOAD:
                if (cmd.font_addr < GLYPHS)
                begin
                    glyph_mirror[cmd.font_addr] = cmd.font_row;
                    glyph_loaded[cmd.font_addr] = 1'b1;
                    glyph_loads++;
                end
            FUNC_READ:
                if (cmd.byte_addr < FB_BYTES)
                    res.read_byte = frame_mirror[cmd.byte_addr];
            default:
                ;
        endcase
        res.cursor_col = text_col;
        res.cursor_row = text_row;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
                     $realtime, what, results_checked, got, want);
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected word", m_tdata, 0);
            end
            else
            begin
                head_word = expected_words.pop_front();
                if (m_tdata[7:0] !== head_word.char_echo)
                    report_mismatch("char_echo", m_tdata[7:0], head_word.char_echo);
                if (m_tdata[15:8] !== head_word.read_byte)
                    report_mismatch("read_byte", m_tdata[15:8], head_word.read_byte);
                if (m_tdata[23:16] !== head_word.cursor_col)
                    report_mismatch("cursor_col", m_tdata[23:16], head_word.cursor_col);
                if (m_tdata[31:24] !== head_word.cursor_row)
                    report_mismatch("cursor_row", m_tdata[31:24], head_word.cursor_row);
                results_checked++;
            end
        end
    end

    // Stall the result stream at random
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_stall_pct);

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one command word; returns at the falling edge after the accept
    task automatic send_word(glyph_cmd_t cmd);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.func;
        s_tdata  <= {2'b00, cmd.byte_addr, cmd.font_row, cmd.font_addr, cmd.char_code,
                     cmd.pixel_on, cmd.pos_y, cmd.pos_x};
        do
            @(posedge clk);
        while (!s_tready);
        expected_words.push_back(apply_cmd(cmd));
        words_sent++;
        @(negedge clk);
    endtask

    // Random junk in every field, then the function code
    function automatic glyph_cmd_t cmd_of(bit [2:0] f);
        glyph_cmd_t cmd;
        cmd = 65'({$urandom, $urandom, $urandom});
        cmd.func = f;
        return cmd;
    endfunction

    task automatic send_draw(int x, int y, bit on);
        glyph_cmd_t cmd;
        cmd = cmd_of(FUNC_DRAW);
        cmd.pos_x = 8'(x);
        cmd.pos_y = 8'(y);
        cmd.pixel_on = on;
        send_word(cmd);
    endtask

    task automatic send_cursor(int x, int y);
        glyph_cmd_t cmd;
        cmd = cmd_of(FUNC_SETCUR);
        cmd.pos_x = 8'(x);
        cmd.pos_y = 8'(y);
        send_word(cmd);
    endtask

    task automatic send_load(int addr, bit [15:0] row);
        glyph_cmd_t cmd;
        cmd = cmd_of(FUNC_LOAD);
        cmd.font_addr = 11'(addr);
        cmd.font_row = row;
        send_word(cmd);
    endtask

    task automatic send_read(int addr);
        glyph_cmd_t cmd;
        cmd = cmd_of(FUNC_READ);
        cmd.byte_addr = 10'(addr);
        send_word(cmd);
    endtask

    task automatic send_func(bit [2:0] f);
        send_word(cmd_of(f));
    endtask

    // Write a character; load any glyph row it would read that was never loaded
    task automatic send_glyph(int c);
        glyph_cmd_t cmd;
        int         base;
        int         i;
        if (c >= FIRST_PRINT && c <= LAST_PRINT &&
            text_col + glyph_w <= SCR_W && text_row + glyph_h <= SCR_H)
        begin
            base = (c - FIRST_PRINT) * glyph_h;
            for (i = 0; i < glyph_h; i++)
                if (base + i < GLYPHS && !glyph_loaded[base + i])
                    send_load(base + i, 16'($urandom));
        end
        cmd = cmd_of(FUNC_CHAR);
        cmd.char_code = 8'(c);
        send_word(cmd);
    endtask

    // Drop valid and wait until every result is back and the block has settled
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_glyph_reg(logic idx, bit [4:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {27'($urandom_range(32'h07FF_FFFF)), val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GLYPH_WIDTH)
            glyph_w = val;
        else
            glyph_h = val;
    endtask

    task automatic set_glyph_size(bit [4:0] w, bit [4:0] h);
        quiesce();
        write_glyph_reg(REG_GLYPH_WIDTH, w);
        write_glyph_reg(REG_GLYPH_HEIGHT, h);
        size_settings++;
    endtask

    task automatic set_idling(int idle_pct, int stall_pct);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
    endtask

    // One random step: a lone command or a short text run
    task automatic random_step();
        int pick;
        int x0;
        int y0;
        int xmax;
        int top_page;
        int bot_page;
        int page;
        int k;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            if ($urandom_range(4) != 0)
                send_draw($urandom_range(SCR_W - 1), $urandom_range(SCR_H - 1),
                          1'($urandom_range(1)));
            else
                send_draw($urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
        end
        else if (pick < 25)
        begin
            send_cursor($urandom_range(255), $urandom_range(255));
        end
        else if (pick < 35)
        begin
            send_glyph($urandom_range(255));
        end
        else if (pick < 65)
        begin
            // place the cursor where a glyph fits, write a few characters, read them back
            x0 = $urandom_range(SCR_W - glyph_w);
            y0 = $urandom_range(SCR_H - glyph_h);
            send_cursor(x0, y0);
            k = $urandom_range(1, 6);
            repeat (k)
                send_glyph(($urandom_range(9) == 0) ? $urandom_range(255)
                                                    : $urandom_range(LAST_PRINT, FIRST_PRINT));
            xmax = (text_col < SCR_W) ? text_col : SCR_W - 1;
            if (x0 > xmax)
                x0 = xmax;
            top_page = (y0 / 8 < LAST_PAGE) ? y0 / 8 : LAST_PAGE;
            bot_page = ((y0 + glyph_h) / 8 < LAST_PAGE) ? (y0 + glyph_h) / 8 : LAST_PAGE;
            repeat ($urandom_range(1, 3))
            begin
                page = $urandom_range(bot_page, top_page);
                send_read($urandom_range(xmax, x0) + SCR_W * page);
            end
        end
        else if (pick < 73)
        begin
            send_load($urandom_range(GLYPHS - 1), 16'($urandom));
        end
        else if (pick < 93)
        begin
            send_read($urandom_range(FB_BYTES - 1));
        end
        else if (pick < 94)
        begin
            send_func(FUNC_CLEAR);
        end
        else if (pick < 95)
        begin
            send_func(FUNC_FILL);
        end
        else if (pick < 97)
        begin
            send_func(FUNC_UNUSED);
        end
        else if (text_col < SCR_W && text_row < SCR_H)
        begin
            send_read(text_col + SCR_W * (text_row / 8));
        end
        else
        begin
            send_read($urandom_range(FB_BYTES - 1));
        end
    endtask

    // Keep stepping until count words, glyph loads included, have gone out
    task automatic run_random(int count);
        int start;
        start = words_sent;
        while (words_sent - start < count)
        begin
            random_step();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every function and the edge cases, with a 16x2 glyph
    task automatic test_directed();
        set_glyph_size(5'd16, 5'd2);
        set_idling(0, 0);
        send_read(FB_BYTES - 1);
        send_draw(0, 0, 1'b1);
        send_draw(0, 1, 1'b1);
        send_draw(0, 0, 1'b0);
        send_draw(SCR_W - 1, SCR_H - 1, 1'b1);
        send_draw(SCR_W, 0, 1'b1);
        send_draw(0, SCR_H, 1'b1);
        send_draw(255, 255, 1'b1);
        send_read(0);
        send_read(FB_BYTES - 1);
        send_load(0, 16'hFFFF);
        send_load(1, 16'h8001);
        send_load((LAST_PRINT - FIRST_PRINT) * 2, 16'hA5A5);
        send_load(GLYPHS - 1, 16'h5A5A);
        send_cursor(0, 0);
        send_glyph(FIRST_PRINT);
        send_glyph(LAST_PRINT);
        send_glyph(FIRST_PRINT - 1);
        send_glyph(LAST_PRINT + 1);
        send_read(0);
        send_read(16);
        send_cursor(SCR_W - 8, 0);
        send_glyph(FIRST_PRINT);
        send_cursor(0, SCR_H - 1);
        send_glyph(FIRST_PRINT);
        send_func(FUNC_UNUSED);
        send_func(FUNC_FILL);
        send_read(517);
        send_func(FUNC_CLEAR);
        send_read(517);
    endtask

    // Reset glyph size, back-to-back words both ways
    task automatic test_default_text();
        set_glyph_size(RST_GLYPH_WIDTH, RST_GLYPH_HEIGHT);
        set_idling(0, 0);
        run_random(450);
    endtask

    // Gaps on the input stream, random ordinary glyph sizes
    task automatic test_sender_gaps();
        repeat (2)
        begin
            set_glyph_size(5'($urandom_range(16, 1)), 5'($urandom_range(16, 1)));
            set_idling(58, 0);
            run_random(200);
        end
    endtask

    // Stalls on the result stream
    task automatic test_receiver_stall();
        set_glyph_size(5'd5, 5'd8);
        set_idling(0, 58);
        run_random(400);
    endtask

    // Gaps and stalls together, largest ordinary glyph
    task automatic test_both_sides();
        set_glyph_size(5'd16, 5'd16);
        set_idling(38, 38);
        run_random(300);
    endtask

    // Zero sizes, wide columns, tall glyphs that run past the glyph memory
    task automatic test_odd_sizes();
        set_glyph_size(5'd0, 5'd6);
        set_idling(38, 38);
        run_random(30);
        set_glyph_size(5'd9, 5'd0);
        run_random(30);
        set_glyph_size(5'd0, 5'd0);
        run_random(25);
        set_glyph_size(5'd31, 5'd31);
        set_idling(0, 0);
        run_random(30);
        set_glyph_size(5'd1, 5'd1);
        set_idling(58, 0);
        run_random(30);
        set_glyph_size(5'd20, 5'd12);
        set_idling(0, 58);
        run_random(30);
        set_glyph_size(5'd16, 5'd31);
        set_idling(38, 38);
        run_random(30);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_default_text();
        test_sender_gaps();
        test_receiver_stall();
        test_both_sides();
        test_odd_sizes();
        quiesce();
        repeat (16) @(negedge clk);
        $display("Covered %0d command words over %0d glyph sizes: %0d characters drawn,",
                 words_sent, size_settings, chars_drawn);
        $display("%0d glyph rows loaded, %0d result words checked, %0d mismatches.",
                 glyph_loads, results_checked, errors);
        if (errors == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
